FILE: sv/fractal_escape_time_iterator_assert.svh
// assertion macros for the escape-time iterator checker
// depends on a clk and an active-low arst_n in the scope of use
`ifndef FRACTAL_ESCAPE_TIME_ITERATOR_ASSERT_SVH
`define FRACTAL_ESCAPE_TIME_ITERATOR_ASSERT_SVH

// same-cycle implication
`define FET_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define FET_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/fet_pkg.sv
// shared types and constants of the escape-time iterator
// used by the controller, the datapath, the top level and the checker
package fet_pkg;

	localparam int COMP_W   = 32;
	localparam int COUNT_W  = 17;
	localparam int LIMIT_W  = 16;
	localparam int RADIUS_W = 13;
	localparam int CFG_IDX_W = 4;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_START_RE   = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_START_IM   = 4'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ITER_LIMIT = 4'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_SQ  = 4'd3;

	localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 16'd64;
	localparam logic [RADIUS_W-1:0] RADIUS_RESET = 13'd400;

	typedef struct packed {
		logic signed [COMP_W-1:0] point_re;
		logic signed [COMP_W-1:0] point_im;
	} point_t;

	typedef struct packed {
		logic [COUNT_W-1:0] iteration_count;
		logic               escaped;
	} result_t;

	typedef struct packed {
		logic load;
		logic mul;
		logic advance;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic done;
	} status_t;

endpackage

FILE: sv/fet_ctrl.sv
// sequencing state machine of the escape-time iterator
// depends on fet_pkg for command and status types
module fet_ctrl
	import fet_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	output cmd_t    cmd,
	input  status_t status
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_MUL  = 2'd1;
	localparam logic [1:0] S_ADD  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_valid_q;
	logic       out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_MUL;
				end
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_ADD;
			end
			S_ADD: begin
				if (!status.done) begin
					cmd.advance = 1'b1;
					state_d     = S_MUL;
				end else if (out_free) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: sv/fet_dpath.sv
// datapath of the escape-time iterator: config registers, z, squares, step and tests
// depends on fet_pkg for payload, command and status types
module fet_dpath
	import fet_pkg::*;
#(
	parameter int FRAC_BITS = 28
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  point_t                in_data,
	input  cmd_t                  cmd,
	output status_t               status,
	output result_t               out_data
);

	localparam int PROD_W = 2 * COMP_W;
	localparam int STEP_W = PROD_W + 2;
	localparam int CMP_W  = (2 * FRAC_BITS + RADIUS_W > PROD_W) ?
	                        (2 * FRAC_BITS + RADIUS_W) : PROD_W;

	logic signed [COMP_W-1:0] start_re_q;
	logic signed [COMP_W-1:0] start_im_q;
	logic [LIMIT_W-1:0]       limit_q;
	logic [RADIUS_W-1:0]      radius_q;

	logic signed [COMP_W-1:0] z_re_q;
	logic signed [COMP_W-1:0] z_im_q;
	logic signed [COMP_W-1:0] c_re_q;
	logic signed [COMP_W-1:0] c_im_q;
	logic [COUNT_W-1:0]       count_q;

	logic signed [PROD_W-1:0] rr_q;
	logic signed [PROD_W-1:0] ii_q;
	logic signed [PROD_W-1:0] ri_q;
	logic signed [PROD_W-1:0] rr_d;
	logic signed [PROD_W-1:0] ii_d;
	logic signed [PROD_W-1:0] ri_d;

	logic signed [PROD_W-1:0] diff;
	logic signed [PROD_W-1:0] re_sh;
	logic signed [PROD_W-1:0] im_sh;
	logic signed [STEP_W-1:0] new_re;
	logic signed [STEP_W-1:0] new_im;
	logic                     ovf;
	logic [PROD_W-1:0]        mod_sum;
	logic [CMP_W-1:0]         mod_ext;
	logic [CMP_W-1:0]         bound_ext;
	logic                     first;
	logic                     beyond_hit;
	logic                     limit_hit;
	logic [COUNT_W-1:0]       count_inc;
	result_t                  res;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_re_q <= '0;
			start_im_q <= '0;
			limit_q    <= LIMIT_RESET;
			radius_q   <= RADIUS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_START_RE:   start_re_q <= cfg_data[COMP_W-1:0];
				CFG_START_IM:   start_im_q <= cfg_data[COMP_W-1:0];
				CFG_ITER_LIMIT: limit_q    <= cfg_data[LIMIT_W-1:0];
				CFG_RADIUS_SQ:  radius_q   <= cfg_data[RADIUS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// squares and cross product of the current z
	assign rr_d = z_re_q * z_re_q;
	assign ii_d = z_im_q * z_im_q;
	assign ri_d = z_re_q * z_im_q;

	// next z with floor scaling, plus overflow test
	assign diff   = rr_q - ii_q;
	assign re_sh  = diff >>> FRAC_BITS;
	assign im_sh  = ri_q >>> (FRAC_BITS - 1);
	assign new_re = {{2{re_sh[PROD_W-1]}}, re_sh}
	              + {{(STEP_W-COMP_W){c_re_q[COMP_W-1]}}, c_re_q};
	assign new_im = {{2{im_sh[PROD_W-1]}}, im_sh}
	              + {{(STEP_W-COMP_W){c_im_q[COMP_W-1]}}, c_im_q};
	assign ovf = (new_re[STEP_W-1:COMP_W-1] != {(STEP_W-COMP_W+1){new_re[STEP_W-1]}})
	          || (new_im[STEP_W-1:COMP_W-1] != {(STEP_W-COMP_W+1){new_im[STEP_W-1]}});

	// exact squared-modulus test of the current z
	assign mod_sum   = rr_q + ii_q;
	assign mod_ext   = CMP_W'(mod_sum);
	assign bound_ext = CMP_W'(radius_q) << (2 * FRAC_BITS);

	assign first      = (count_q == '0);
	assign beyond_hit = !first && (mod_ext > bound_ext);
	assign limit_hit  = !first && (count_q > {1'b0, limit_q});
	assign count_inc  = count_q + 1'b1;

	always_comb begin
		res.escaped = beyond_hit || (!limit_hit && ovf);
		if (beyond_hit || limit_hit) begin
			res.iteration_count = count_q;
		end else begin
			res.iteration_count = count_inc;
		end
	end

	assign status.done = beyond_hit || limit_hit || ovf;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			z_re_q  <= start_re_q;
			z_im_q  <= start_im_q;
			c_re_q  <= in_data.point_re;
			c_im_q  <= in_data.point_im;
			count_q <= '0;
		end else if (cmd.advance) begin
			z_re_q  <= new_re[COMP_W-1:0];
			z_im_q  <= new_im[COMP_W-1:0];
			count_q <= count_inc;
		end
		if (cmd.mul) begin
			rr_q <= rr_d;
			ii_q <= ii_d;
			ri_q <= ri_d;
		end
		if (cmd.finish) begin
			out_data <= res;
		end
	end

endmodule

FILE: sv/fractal_escape_time_iterator.sv
// Escape-time iterator: per point c, iterates z = z*z + c from a configured start.
// Input channel in_valid/in_ready/in_data carries one point item (signed fixed point).
// Output channel out_valid/out_ready/out_data carries the iteration count and the
// escaped flag. Config channel cfg_valid/cfg_ready/cfg_index/cfg_data writes start_re,
// start_im, iteration_limit and escape_radius_sq. cfg_ready is always high; the user
// must write config only while no item is in flight, which the block does not enforce.
// One item is worked at a time. Each iteration passes the three 32x32 multipliers (two
// squares and the cross product), then the add, scale and compare stage. A result
// that stops on radius or limit is found in the pass after the one that computed its
// last z; one that stops on overflow, in the pass that computes the overflowing z.
// in_ready is high while the block is idle, also while a finished result waits in the
// output register. If the receiver stalls, a finished item holds in the last stage
// until the output register frees, and no further item is accepted meanwhile.
// Reset clears the controller and the output valid and restores the config registers
// to start 0, limit 64 and squared radius 400.
module fractal_escape_time_iterator
	import fet_pkg::*;
#(
	parameter int FRAC_BITS = 28
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  point_t                in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output result_t               out_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cmd_t    cmd;
	status_t status;

	assign cfg_ready = 1'b1;

	fet_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.status    (status)
	);

	fet_dpath #(
		.FRAC_BITS (FRAC_BITS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.cmd       (cmd),
		.status    (status),
		.out_data  (out_data)
	);

endmodule

FILE: sv/fet_check.sv
// port-level checker of the escape-time iterator, bound to the top level
// depends on fet_pkg and fractal_escape_time_iterator_assert.svh
`include "fractal_escape_time_iterator_assert.svh"

module fet_check
	import fet_pkg::*;
(
	input logic    clk,
	input logic    arst_n,
	input logic    in_valid,
	input logic    in_ready,
	input logic    out_valid,
	input logic    out_ready,
	input result_t out_data
);

	logic               out_stall;
	logic               in_take;
	logic [COUNT_W-1:0] result_count;
	logic               count_top;
	logic [COUNT_W-2:0] count_low;

	assign out_stall    = out_valid && !out_ready;
	assign in_take      = in_valid && in_ready;
	assign result_count = out_data.iteration_count;
	assign count_top    = out_valid && result_count[COUNT_W-1];
	assign count_low    = result_count[COUNT_W-2:0];

	`FET_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(out_data), "held result changed")
	`FET_ASSERT_NEXT(a_one_item, in_take, !in_ready, "second item taken while one is in flight")
	`FET_ASSERT_NOW(a_count_nonzero, out_valid, result_count != '0, "result with zero iterations")
	`FET_ASSERT_NOW(a_count_bound, count_top, count_low == '0, "iteration count beyond range")

endmodule

bind fractal_escape_time_iterator fet_check u_check (.*);

FILE: verif/tb_top.sv
// testbench of fractal_escape_time_iterator: random and directed points, self-checking
// keeps its own escape-time prediction and compares every result item in order
// depends on fet_pkg and the fractal_escape_time_iterator top level
module tb_top
	import fet_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAC = 28;
	localparam longint COMP_MAX = 64'sd2147483647;
	localparam longint COMP_MIN = -64'sd2147483648;
	localparam longint unsigned SQ_FRAC_MASK = (64'd1 << (2 * FRAC)) - 64'd1;
	localparam logic signed [COMP_W-1:0] ONE = 32'sh1000_0000;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	point_t                in_data = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	result_t               out_data;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	logic signed [COMP_W-1:0] cfg_start_re = '0;
	logic signed [COMP_W-1:0] cfg_start_im = '0;
	logic [LIMIT_W-1:0]       cfg_limit = LIMIT_RESET;
	logic [RADIUS_W-1:0]      cfg_radius_sq = RADIUS_RESET;

	point_t      point_q[$];
	result_t     escape_q[$];
	bit          in_fire = 1'b0;
	bit          cfg_fire = 1'b0;
	int unsigned send_idle = 0;
	int unsigned recv_idle = 0;
	int unsigned n_fail = 0;

	fractal_escape_time_iterator #(
		.FRAC_BITS(FRAC)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#40_000_000;
		$display("fractal_escape_time_iterator: mismatch");
		$finish;
	end

	function automatic result_t escape_time(point_t pt);
		longint zr, zi, nr, ni;
		longint unsigned mag;
		int unsigned steps;
		bit stop, esc;
		result_t res;
		zr = cfg_start_re;
		zi = cfg_start_im;
		steps = 0;
		stop = 1'b0;
		esc = 1'b0;
		while (!stop) begin
			nr = ((zr * zr - zi * zi) >>> FRAC) + longint'(pt.point_re);
			ni = ((zr * zi) >>> (FRAC - 1)) + longint'(pt.point_im);
			steps++;
			if (nr < COMP_MIN || nr > COMP_MAX || ni < COMP_MIN || ni > COMP_MAX) begin
				esc = 1'b1;
				stop = 1'b1;
			end else begin
				zr = nr;
				zi = ni;
				mag = zr * zr;
				mag += zi * zi;
				if ((mag >> (2 * FRAC)) > cfg_radius_sq ||
				    ((mag >> (2 * FRAC)) == cfg_radius_sq && (mag & SQ_FRAC_MASK) != 0)) begin
					esc = 1'b1;
					stop = 1'b1;
				end else if (steps > cfg_limit) begin
					stop = 1'b1;
				end
			end
		end
		res.iteration_count = steps[COUNT_W-1:0];
		res.escaped = esc;
		return res;
	endfunction

	// driver and receiver, both move at the falling edge
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_fire) begin
				if (point_q.size() != 0 && $urandom_range(99) >= send_idle) begin
					in_valid <= 1'b1;
					in_data <= point_q.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
			in_fire = 1'b0;
			out_ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	always @(posedge clk) begin : monitor
		result_t want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_START_RE: cfg_start_re = cfg_data;
					CFG_START_IM: cfg_start_im = cfg_data;
					CFG_ITER_LIMIT: cfg_limit = cfg_data[LIMIT_W-1:0];
					CFG_RADIUS_SQ: cfg_radius_sq = cfg_data[RADIUS_W-1:0];
					default: ;
				endcase
				cfg_fire = 1'b1;
			end
			if (in_valid && in_ready) begin
				escape_q.push_back(escape_time(in_data));
				in_fire = 1'b1;
			end
			if (out_valid && out_ready) begin
				if (escape_q.size() == 0) begin
					$error("result item with none expected: iteration_count %0d escaped %0b",
						out_data.iteration_count, out_data.escaped);
					n_fail++;
				end else begin
					want = escape_q.pop_front();
					if (out_data.iteration_count !== want.iteration_count) begin
						$error("iteration_count: expected %0d, got %0d",
							want.iteration_count, out_data.iteration_count);
						n_fail++;
					end
					if (out_data.escaped !== want.escaped) begin
						$error("escaped: expected %0b, got %0b", want.escaped, out_data.escaped);
						n_fail++;
					end
				end
			end
		end
	end

	task automatic add_point(input logic signed [COMP_W-1:0] re, input logic signed [COMP_W-1:0] im);
		point_t p;
		p.point_re = re;
		p.point_im = im;
		point_q.push_back(p);
	endtask

	task automatic queue_points(input int n, input int unsigned near_pct);
		point_t p;
		repeat (n) begin
			if ($urandom_range(99) < near_pct) begin
				p.point_re = $urandom_range(32'h4000_0000) - 32'h2000_0000;
				p.point_im = $urandom_range(32'h4000_0000) - 32'h2000_0000;
			end else begin
				p.point_re = $urandom;
				p.point_im = $urandom;
			end
			point_q.push_back(p);
		end
	endtask

	task automatic wait_idle();
		do begin
			@(posedge clk);
			#1;
		end while (point_q.size() != 0 || in_valid || escape_q.size() != 0);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(negedge clk); while (!cfg_fire);
		cfg_fire = 1'b0;
		cfg_valid <= 1'b0;
	endtask

	task automatic configure(input logic [CFG_DATA_W-1:0] sr, input logic [CFG_DATA_W-1:0] si,
		input logic [CFG_DATA_W-1:0] lim, input logic [CFG_DATA_W-1:0] rad);
		wait_idle();
		write_reg(CFG_START_RE, sr);
		write_reg(CFG_START_IM, si);
		write_reg(CFG_ITER_LIMIT, lim);
		write_reg(CFG_RADIUS_SQ, rad);
	endtask

	initial begin : stimulus
		logic [COMP_W-1:0] mag_re;
		int i;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		send_idle = 12;
		recv_idle = 84;

		// directed points under the reset settings
		add_point(0, 0);
		add_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
		add_point(32'sh8000_0000, 32'sh8000_0000);
		add_point(32'sh7FFF_FFFF, 32'sh8000_0000);
		add_point(32'sh8000_0000, 0);
		add_point(0, 32'sh8000_0000);
		add_point(0, 32'sh7FFF_FFFF);
		add_point(-2 * ONE, 0);
		add_point(2 * ONE, 0);
		add_point(ONE / 4, 0);
		add_point(-(ONE / 2 + ONE / 4), 0);
		add_point(0, ONE);
		add_point(-ONE, 0);
		add_point(1, 0);
		add_point(-1, -1);
		add_point(0, -1);
		add_point(ONE / 2, 0);
		add_point(32'sh04CC_CCCD, 32'sh0800_0000);
		add_point(-32'sh0199_999A, 32'sh0A66_6666);
		add_point(-ONE - ONE / 4, 0);
		add_point(ONE / 4 + 1, 0);

		configure(0, 0, 64, 400);
		queue_points(350, 70);
		configure($urandom_range(32'h2000_0000) - 32'h1000_0000,
			$urandom_range(32'h2000_0000) - 32'h1000_0000, 100, 4);
		queue_points(200, 80);

		wait_idle();
		send_idle = 84;
		recv_idle = 12;
		configure(0, 0, 0, 0);
		add_point(0, 0);
		queue_points(60, 60);
		configure(32'h7FFF_FFFF, 32'h8000_0000, 1, 4096);
		queue_points(40, 60);
		configure($urandom_range(32'h1000_0000) - 32'h0800_0000,
			$urandom_range(32'h1000_0000) - 32'h0800_0000, 7, 1);
		queue_points(100, 80);
		configure(32'h8000_0000, 32'h7FFF_FFFF, 65535, 4);
		add_point(-ONE, 0);
		configure(0, 0, 65535, 4);
		add_point(0, 0);
		add_point(-ONE, 0);
		for (i = 0; i < 30; i++) begin
			mag_re = $urandom_range(32'h7FFF_FFFF, 32'h2000_0001);
			add_point($urandom_range(1) ? mag_re : -mag_re, $urandom);
		end

		wait_idle();
		send_idle = 0;
		recv_idle = 0;
		configure(0, 0, 64, 400);
		queue_points(270, 70);
		configure($urandom_range(32'h2000_0000) - 32'h1000_0000,
			$urandom_range(32'h2000_0000) - 32'h1000_0000, 32, 2);
		queue_points(100, 80);

		wait_idle();
		repeat (300) @(posedge clk);
		if (n_fail == 0) begin
			$display("fractal_escape_time_iterator: match");
		end else begin
			$display("fractal_escape_time_iterator: mismatch");
		end
		$finish;
	end

endmodule
